FILE: design/lpma_pkg.sv
// Package for the light percentage moving average unit.
// Holds field widths, fixed-point constants, the sequencer control word types
// and the sequencer program. No dependencies.
package lpma_pkg;

	localparam int ADC_W   = 12;
	localparam int LEVEL_W = 15;
	localparam int PROD_W  = ADC_W + LEVEL_W;
	localparam int STEP_W  = 3;
	localparam int CNT_W   = 4;

	localparam logic [ADC_W-1:0]   ADC_FULL     = {ADC_W{1'b1}};
	localparam logic [LEVEL_W-1:0] PERCENT_FULL = LEVEL_W'(25600);
	localparam logic [CNT_W-1:0]   DIV_LAST     = CNT_W'(LEVEL_W - 1);

	// Datapath operation selected by one control word.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_TAKE,
		OP_MUL,
		OP_STORE,
		OP_DINIT,
		OP_DSTEP,
		OP_FINISH
	} op_t;

	// Jump condition: when true the sequencer goes to the target step,
	// otherwise to the following one.
	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_REQ,
		C_NOT_OK,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic req;
		logic ok;
		logic div_more;
		logic out_busy;
	} status_t;

	localparam logic [STEP_W-1:0] S_WAIT   = 3'd0;
	localparam logic [STEP_W-1:0] S_MUL    = 3'd1;
	localparam logic [STEP_W-1:0] S_STORE  = 3'd2;
	localparam logic [STEP_W-1:0] S_DINIT  = 3'd3;
	localparam logic [STEP_W-1:0] S_DSTEP  = 3'd4;
	localparam logic [STEP_W-1:0] S_FINISH = 3'd5;
	localparam logic [STEP_W-1:0] S_RET    = 3'd6;

	// The program ROM. Unused addresses fall back to the wait step.
	function automatic ctrl_t prog_word(input logic [STEP_W-1:0] step);
		ctrl_t w;
		begin
			unique case (step)
				S_WAIT:   w = '{op: OP_TAKE,   cond: C_NO_REQ,   target: S_WAIT};
				S_MUL:    w = '{op: OP_MUL,    cond: C_NOT_OK,   target: S_FINISH};
				S_STORE:  w = '{op: OP_STORE,  cond: C_NEXT,     target: S_WAIT};
				S_DINIT:  w = '{op: OP_DINIT,  cond: C_NEXT,     target: S_WAIT};
				S_DSTEP:  w = '{op: OP_DSTEP,  cond: C_DIV_MORE, target: S_DSTEP};
				S_FINISH: w = '{op: OP_FINISH, cond: C_OUT_BUSY, target: S_FINISH};
				S_RET:    w = '{op: OP_NOP,    cond: C_ALWAYS,   target: S_WAIT};
				default:  w = '{op: OP_NOP,    cond: C_ALWAYS,   target: S_WAIT};
			endcase
			return w;
		end
	endfunction

endpackage

FILE: design/light_percent_moving_average_unit.sv
// A good sample runs the multiply, store, divide-init, 15-step divide of the mean
// and finish steps; a failed read goes from multiply straight to finish. The next
// request is only taken back in the wait step; a result waiting in the output
// register keeps the sequencer in its finish step and so holds off the next request.
// Reset (arst_n, asynchronous, active low) clears the sequencer, the fill count,
// write position, running sum, last level and the scale register at once.
module light_percent_moving_average_unit import lpma_pkg::*; #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic               cfg_write_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ADC_W-1:0]   adc_sample,
	input  logic               sample_ok,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [LEVEL_W-1:0] light_level
);

	// Ring pointer, fill count and running sum widths follow the window depth.
	// The running sum holds at most WINDOW_DEPTH full-scale entries.
	localparam int POS_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = $clog2(WINDOW_DEPTH * 25600 + 1);

	ctrl_t   ctrl;
	status_t status;

	logic                invert_q;
	logic [ADC_W-1:0]    adc_q;
	logic                ok_q;
	logic [PROD_W-1:0]   prod_q;
	logic [POS_W-1:0]    wpos_q;
	logic [FILL_W-1:0]   fill_q;
	logic [SUM_W-1:0]    sum_q;
	logic [LEVEL_W-1:0]  rd_q;
	logic [FILL_W-1:0]   rem_q;
	logic [LEVEL_W-1:0]  quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [LEVEL_W-1:0]  last_q;
	logic                out_valid_q;
	logic [LEVEL_W-1:0]  level_q;

	logic [LEVEL_W-1:0]  store_mem [WINDOW_DEPTH];

	logic                accept;
	logic                full;
	logic                out_busy;
	logic                store_en;
	logic [ADC_W-1:0]    num;
	logic [LEVEL_W-1:0]  scaled;
	logic [SUM_W-1:0]    old_entry;
	logic [FILL_W:0]     trial;
	logic                quo_bit;

	lpma_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// The sequencer only accepts a request in its wait step.
	assign in_ready = (ctrl.op == OP_TAKE);
	assign accept   = in_valid && in_ready;
	assign out_busy = out_valid_q && !out_ready;
	assign full     = (fill_q == FILL_W'(WINDOW_DEPTH));
	assign store_en = (ctrl.op == OP_STORE);

	assign status = '{req: accept, ok: ok_q, div_more: (cnt_q != '0), out_busy: out_busy};

	assign out_valid   = out_valid_q;
	assign light_level = level_q;

	// Falling scale uses 4095 - reading, which is the bitwise complement for 12 bits.
	assign num = invert_q ? adc_q : (ADC_FULL - adc_q);

	// Division of the product by 4095 = 4096 - 1. Writing t = q0*4096 + lo gives
	// t = q0*4095 + (lo + q0); the remainder is folded once more, after which a
	// single compare corrects the last unit. The result never exceeds 25600, but
	// it is clamped anyway so the store can only ever hold a legal level.
	function automatic logic [LEVEL_W-1:0] div_full_scale(input logic [PROD_W-1:0] t);
		logic [LEVEL_W-1:0] q0;
		logic [LEVEL_W:0]   r0;
		logic [3:0]         q1;
		logic [ADC_W:0]     r1;
		logic [LEVEL_W:0]   q;
		begin
			q0 = t[PROD_W-1:ADC_W];
			r0 = (LEVEL_W + 1)'(t[ADC_W-1:0]) + (LEVEL_W + 1)'(q0);
			q1 = r0[ADC_W+3:ADC_W];
			r1 = (ADC_W + 1)'(r0[ADC_W-1:0]) + (ADC_W + 1)'(q1);
			q  = (LEVEL_W + 1)'(q0) + (LEVEL_W + 1)'(q1)
			   + (LEVEL_W + 1)'(r1 >= (ADC_W + 1)'(ADC_FULL));
			if (q > (LEVEL_W + 1)'(PERCENT_FULL)) begin
				q = (LEVEL_W + 1)'(PERCENT_FULL);
			end
			return q[LEVEL_W-1:0];
		end
	endfunction

	assign scaled = div_full_scale(prod_q);

	// The entry being overwritten leaves the running sum only once the ring is
	// full; before that the slot at the write position was never counted.
	assign old_entry = full ? SUM_W'(rd_q) : '0;

	// Restoring divide step: shift the next dividend bit into the remainder.
	assign trial   = {rem_q, quo_q[LEVEL_W-1]};
	assign quo_bit = (trial >= (FILL_W + 1)'(fill_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
		end else if (cfg_write_en) begin
			invert_q <= cfg_write_data;
		end
	end

	// Ring store. Only entries below the fill count are ever summed, and those
	// have all been written, so the store needs no clearing.
	always_ff @(posedge clk) begin
		if (store_en) begin
			store_mem[wpos_q] <= scaled;
		end
		rd_q <= store_mem[wpos_q];
	end

	// Payload registers of the datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			adc_q <= adc_sample;
		end
		if (ctrl.op == OP_MUL) begin
			prod_q <= PROD_W'(num) * PROD_W'(PERCENT_FULL);
		end
		if (ctrl.op == OP_DINIT) begin
			// The mean fits in LEVEL_W bits, so the bits above them are already
			// smaller than the divisor and start as the remainder.
			rem_q <= FILL_W'(sum_q >> LEVEL_W);
			quo_q <= sum_q[LEVEL_W-1:0];
		end else if (ctrl.op == OP_DSTEP) begin
			rem_q <= quo_bit ? FILL_W'(trial - (FILL_W + 1)'(fill_q)) : trial[FILL_W-1:0];
			quo_q <= {quo_q[LEVEL_W-2:0], quo_bit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q        <= 1'b0;
			wpos_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
			level_q     <= '0;
		end else begin
			if (accept) begin
				ok_q <= sample_ok;
			end
			if (store_en) begin
				sum_q <= sum_q - old_entry + SUM_W'(scaled);
				if (wpos_q == POS_W'(WINDOW_DEPTH - 1)) begin
					wpos_q <= '0;
				end else begin
					wpos_q <= wpos_q + POS_W'(1);
				end
				if (!full) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
			if (ctrl.op == OP_DINIT) begin
				cnt_q <= DIV_LAST;
			end else if (ctrl.op == OP_DSTEP && cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			// A failed read repeats the last level; a good one publishes the mean.
			if (ctrl.op == OP_FINISH && !out_busy) begin
				out_valid_q <= 1'b1;
				level_q     <= ok_q ? quo_q : last_q;
				if (ok_q) begin
					last_q <= quo_q;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_DEPTH))
		else $error("fill count exceeds window depth");

	a_wpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= POS_W'(WINDOW_DEPTH - 1))
		else $error("write position outside the ring");

	a_fill_only_on_store: assert property (@(posedge clk) disable iff (!arst_n)
		!store_en |=> $stable(fill_q) && $stable(sum_q))
		else $error("ring state changed without a stored sample");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> level_q <= PERCENT_FULL)
		else $error("light level above full scale");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_DSTEP |-> !in_ready && fill_q != '0)
		else $error("divide running without a filled sample or while ready");
`endif

endmodule

FILE: design/lpma_seq.sv
// Microcode sequencer of the light percentage moving average unit.
// Step counter, program ROM and jump logic; depends on lpma_pkg.
module lpma_seq import lpma_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctrl_t   ctrl
);

	logic [STEP_W-1:0] step_q;
	logic              jump;

	assign ctrl = prog_word(step_q);

	always_comb begin
		unique case (ctrl.cond)
			C_NEXT:     jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_REQ:   jump = !status.req;
			C_NOT_OK:   jump = !status.ok;
			C_DIV_MORE: jump = status.div_more;
			C_OUT_BUSY: jump = status.out_busy;
			default:    jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_WAIT;
		end else if (jump) begin
			step_q <= ctrl.target;
		end else begin
			step_q <= step_q + STEP_W'(1);
		end
	end

endmodule

FILE: dv/light_percent_moving_average_unit_tb.sv
// Testbench for light_percent_moving_average_unit: sends ADC sample requests, predicts each
// averaged light level with a scoreboard of its own and compares every level that comes back.
// Depends on lpma_pkg, the RTL top level and its lpma_seq; nothing else is read or needed.
module light_percent_moving_average_unit_tb import lpma_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_SIZE    = 8;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int SETTLE_CYCLES  = 25;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int IDLE_PCT       = 34;
	localparam int FAILED_PCT     = 20;

	// The scoreboard keeps its own copy of the ring, the write slot, the fill count and
	// the last level. Every accepted request yields exactly one expected level, which is
	// queued in request order and popped when the block hands a level back.
	class level_scoreboard #(int WINDOW = 8);
		logic [LEVEL_W-1:0] ring [WINDOW];
		int unsigned        wr_pos;
		int unsigned        filled;
		logic [LEVEL_W-1:0] last_level;
		logic               invert;
		logic [LEVEL_W-1:0] level_q [$];
		int unsigned        errors;
		int unsigned        checked;
		int unsigned        good_reads;
		int unsigned        failed_reads;

		function new();
			foreach (ring[i]) ring[i] = '0;
			wr_pos       = 0;
			filled       = 0;
			last_level   = '0;
			invert       = 1'b0;
			errors       = 0;
			checked      = 0;
			good_reads   = 0;
			failed_reads = 0;
		endfunction

		// Scale a good sample into 1/256 percent, push it into the ring and take the
		// truncated mean of the filled entries. A failed read leaves the ring, fill count and last level alone.
		function void note_request(logic [ADC_W-1:0] raw, logic ok);
			int unsigned num;
			int unsigned pct;
			int unsigned sum;
			if (ok) begin
				num = invert ? raw : (ADC_FULL - raw);
				pct = (num * PERCENT_FULL) / ADC_FULL;
				if (pct > PERCENT_FULL) begin
					pct = PERCENT_FULL;
				end
				ring[wr_pos] = pct[LEVEL_W-1:0];
				wr_pos = (wr_pos + 1) % WINDOW;
				if (filled < WINDOW) begin
					filled++;
				end
				sum = 0;
				for (int i = 0; i < filled; i++) begin
					sum += ring[i];
				end
				last_level = LEVEL_W'(sum / filled);
				good_reads++;
			end else begin
				failed_reads++;
			end
			level_q.push_back(last_level);
		endfunction

		task check_level(logic [LEVEL_W-1:0] got);
			logic [LEVEL_W-1:0] want;
			if (level_q.size() == 0) begin
				report("light_level with no request outstanding", got, 'x);
				return;
			end
			want = level_q.pop_front();
			checked++;
			if (got !== want) begin
				report("light_level mismatch", got, want);
			end
		endtask

		task report(string what, logic [LEVEL_W-1:0] got, logic [LEVEL_W-1:0] want);
			errors++;
			if (errors <= 40) begin
				$display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
			end
		endtask
	endclass

	// All inputs of the block start at known values.
	logic clk            = 1'b0;
	logic arst_n         = 1'b0;
	logic cfg_write_en   = 1'b0;
	logic cfg_write_data = 1'b0;
	logic in_valid       = 1'b0;
	logic [ADC_W-1:0] adc_sample = '0;
	logic sample_ok      = 1'b0;
	logic out_ready      = 1'b0;

	logic               in_ready;
	logic               out_valid;
	logic [LEVEL_W-1:0] light_level;

	// no_gaps and rx_hold_grant are written by the stimulus process with nonblocking
	// assignments only; no_gaps turns off the random idling on both sides. Each increment
	// of rx_hold_grant asks the receiver for one long hold-off, which it times in its own process.
	logic        no_gaps       = 1'b0;
	int unsigned rx_hold_grant = 0;
	int unsigned rx_hold_seen  = 0;
	int          rx_hold_left  = 0;
	int unsigned cycle_count   = 0;

	level_scoreboard #(WINDOW_SIZE) board;

	light_percent_moving_average_unit #(
		.WINDOW_DEPTH(WINDOW_SIZE)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.adc_sample     (adc_sample),
		.sample_ok      (sample_ok),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.light_level    (light_level)
	);

	always #6 clk = ~clk;

	// Watchdog. The slowest correct run is far below this: about 570 requests, plus
	// random gaps on both sides, two long receiver hold-offs and the settle time after
	// each drain.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver. The block's outputs are sampled at the edge, so a level counts as
	// delivered when out_valid and out_ready were both high just before it. out_ready
	// is then chosen for the next cycle: low through a hold-off, high with no_gaps, else random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				board.check_level(light_level);
			end
			if (rx_hold_grant != rx_hold_seen) begin
				rx_hold_seen = rx_hold_grant;
				rx_hold_left = RX_HOLD_CYCLES;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Offer one request and return at the edge where it is taken. in_valid is left
	// high afterwards so that back-to-back requests never drop it within one step;
	// it only goes low inside an idle gap or when the sender drains.
	task automatic send_request(input logic [ADC_W-1:0] raw, input logic ok);
		if (!no_gaps) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid   <= 1'b1;
		adc_sample <= raw;
		sample_ok  <= ok;
		do @(posedge clk); while (!in_ready);
		board.note_request(raw, ok);
	endtask

	// Random requests. Samples lean toward the ends of the converter range, where the
	// scaling is most likely to be off by one, and about one in five is a failed read.
	task automatic send_random(input int count);
		logic [ADC_W-1:0] raw;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(9))
				0: raw = '0;
				1: raw = ADC_FULL;
				2: raw = ADC_W'($urandom_range(15));
				3: raw = ADC_FULL - ADC_W'($urandom_range(15));
				default: raw = ADC_W'($urandom);
			endcase
			send_request(raw, $urandom_range(99) >= FAILED_PCT);
		end
	endtask

	// Stop offering, wait until every expected level has come back, then give the
	// sequencer time to return to its wait step before anything else happens.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (board.level_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The scale register is only written while the block is idle.
	task automatic write_invert(input logic v);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		board.invert = v;
	endtask

	initial begin
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Falling scale, the reset setting. A failed read before any good sample must
		// give zero. Then the ring warms up one entry at a time, so the mean divides by
		// one through eight, and the ninth and tenth good samples wrap the write slot.
		send_request(ADC_FULL, 1'b0);
		send_request('0, 1'b0);
		send_request('0, 1'b1);
		send_request(ADC_FULL, 1'b1);
		send_request(12'd2048, 1'b0);
		send_request(12'd2048, 1'b1);
		send_request(12'd1, 1'b1);
		send_request(12'd4094, 1'b1);
		send_request(12'hAAA, 1'b1);
		send_request(12'h555, 1'b1);
		send_request(ADC_FULL, 1'b1);
		send_request('0, 1'b1);
		send_request(12'd2047, 1'b1);
		send_request(12'd123, 1'b0);

		// Rising scale with the extremes again, on top of the ring filled above.
		wait_idle();
		write_invert(1'b1);
		send_request('0, 1'b1);
		send_request(ADC_FULL, 1'b1);
		send_request(ADC_FULL, 1'b0);
		send_request(12'd2047, 1'b1);
		send_request(12'd1, 1'b1);
		send_request(12'd4094, 1'b1);
		send_request(12'hFFE, 1'b0);

		// Random requests with a long receiver hold-off in the middle. The sender keeps
		// offering, so the output register and then the sequencer fill up and in_ready
		// drops until the receiver takes levels again.
		wait_idle();
		write_invert(1'b0);
		send_random(60);
		rx_hold_grant <= rx_hold_grant + 1;
		send_random(40);

		// A pause on the sender side until every level has been delivered.
		wait_idle();
		send_random(50);

		// A long stretch with no idling on either side, then random idling again.
		wait_idle();
		write_invert(1'b1);
		no_gaps <= 1'b1;
		send_random(120);
		no_gaps <= 1'b0;
		send_random(80);

		wait_idle();
		write_invert(1'b0);
		send_random(100);

		wait_idle();
		write_invert(1'b1);
		rx_hold_grant <= rx_hold_grant + 1;
		send_random(100);

		wait_idle();
		$display("summary: %0d requests (%0d good samples, %0d failed reads), %0d levels checked",
			board.good_reads + board.failed_reads, board.good_reads, board.failed_reads,
			board.checked);
		$display("summary: both scale directions, ring warm-up and wrap, receiver hold-off, %0d errors",
			board.errors);
		if (board.errors == 0 && board.level_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: files.f
design/lpma_pkg.sv
design/lpma_seq.sv
design/light_percent_moving_average_unit.sv
dv/light_percent_moving_average_unit_tb.sv
